// File: design/bpas_pkg.sv
// package: shared constants, types and register map of the alignment score block
`timescale 1ns / 1ps
package bpas_pkg;

    localparam int QUERY_BITS_DEF     = 64;
    localparam int ALPHABET_DEF       = 4;
    localparam int MAX_SCORE_SPAN_DEF = 48;

    // signed width of the per-position difference arithmetic
    localparam int DW = 10;

    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;
    localparam logic [1:0] REG_QLEN     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_FIN,
        S_MUL,
        S_SUM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [3:0] match_score;
        logic [4:0] mismatch_score;
        logic [4:0] gap_score;
        logic [7:0] span;
    } t_scores;

endpackage

// File: design/bpas_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module bpas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bpas_cell_unit.sv
// shared update unit: one query position of the difference column per use
`timescale 1ns / 1ps
module bpas_cell_unit
    import bpas_pkg::*;
#(
    parameter int MAX_SCORE_SPAN = MAX_SCORE_SPAN_DEF
) (
    input  t_scores                              i_scores,
    input  logic [$clog2(MAX_SCORE_SPAN)-1:0]    i_id,
    input  logic                                 i_id_valid,
    input  logic                                 i_eq,
    input  logic signed [DW-1:0]                 i_dv,
    output logic [$clog2(MAX_SCORE_SPAN)-1:0]    o_id,
    output logic signed [DW-1:0]                 o_dh,
    output logic signed [DW-1:0]                 o_dv
);

    localparam int IW = $clog2(MAX_SCORE_SPAN);

    logic signed [DW-1:0] w_gap;
    logic signed [DW-1:0] w_s;
    logic signed [DW-1:0] w_dh;
    logic signed [DW-1:0] w_a;
    logic signed [DW-1:0] w_b;
    logic signed [DW-1:0] w_out;
    logic signed [DW-1:0] w_dhn;
    logic signed [DW-1:0] w_rel;
    logic signed [DW-1:0] w_span;
    logic signed [DW-1:0] w_cid;

    always_comb begin
        w_gap  = DW'($signed(i_scores.gap_score));
        w_s    = i_eq ? DW'($signed({1'b0, i_scores.match_score}))
                      : DW'($signed(i_scores.mismatch_score));
        // an entry never written holds the gap value
        w_dh   = i_id_valid ? w_gap + DW'($signed({1'b0, i_id})) : w_gap;
        w_a    = w_s - w_dh;
        w_b    = i_dv + w_gap - w_dh;
        w_out  = w_gap;
        if (w_a > w_out) begin
            w_out = w_a;
        end
        if (w_b > w_out) begin
            w_out = w_b;
        end
        w_dhn  = w_out + w_dh - i_dv;
        w_rel  = w_dhn - w_gap;
        w_span = DW'($signed(i_scores.span));
        if (w_rel < 0) begin
            w_cid = '0;
        end else if (w_rel >= w_span) begin
            w_cid = w_span - DW'(1);
        end else begin
            w_cid = w_rel;
        end
        o_id = w_cid[IW-1:0];
        o_dh = w_gap + w_cid;
        o_dv = w_out;
    end

endmodule

// File: design/bit_parallel_alignment_score.sv
// Global alignment score of a loaded query against a streamed text, linear gap
// penalty. Query symbols (tuser = 0) are taken while idle; a load at position 0
// clears the query first. Each text symbol (tuser = 1) runs one shared update
// unit over the min(query_length, QUERY_BITS) positions in use, one position
// per cycle, through a registered-read store of per-position differences. The
// last symbol of a text then passes S_MUL and S_SUM to S_DONE, which sends the
// score, and waits there while the output register still holds an unread score.
// Bad score settings are reported with score 0 and config_error set.
// A finished score waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module bit_parallel_alignment_score
    import bpas_pkg::*;
#(
    parameter int QUERY_BITS     = QUERY_BITS_DEF,
    parameter int ALPHABET       = ALPHABET_DEF,
    parameter int MAX_SCORE_SPAN = MAX_SCORE_SPAN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [1:0] symbol, [7:2] position
    input  logic        i_s_axis_tuser,  // [0] mode
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata, // [31:0] score
    output logic        o_m_axis_tuser, // [0] config_error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW   = $clog2(QUERY_BITS);
    localparam int CW   = $clog2(QUERY_BITS + 1);
    localparam int IW   = $clog2(MAX_SCORE_SPAN);
    localparam int MS   = (ALPHABET < 4) ? ALPHABET : 4;
    localparam int SUMW = DW + AW + 1;
    localparam int PW   = 38;
    localparam int TW   = PW + 1;

    t_state r_state, n_state;

    logic [3:0]  r_match;
    logic [4:0]  r_mis;
    logic [4:0]  r_gap;
    logic [6:0]  r_qlen;

    logic [QUERY_BITS-1:0] r_mask [MS];
    logic [QUERY_BITS-1:0] r_valid;
    logic [31:0]           r_text_count;

    logic [1:0]            r_sym;
    logic                  r_last;
    logic [CW-1:0]         r_idx;
    logic                  r_pv;
    logic [AW-1:0]         r_paddr;
    logic                  r_rd_vld;
    logic signed [DW-1:0]  r_dv;
    logic signed [SUMW-1:0] r_sum;
    logic signed [PW-1:0]  r_prod;
    logic [31:0]           r_res_score;
    logic                  r_res_err;

    logic                  r_o_valid;
    logic [31:0]           r_o_score;
    logic                  r_o_err;

    t_scores               w_scores;
    logic signed [7:0]     w_span;
    logic                  w_ok;
    logic [CW-1:0]         w_len;
    logic                  w_in_acc;
    logic                  w_cfg_wr;
    logic                  w_eq;
    logic [IW-1:0]         w_rdata;
    logic [IW-1:0]         w_new_id;
    logic signed [DW-1:0]  w_new_dh;
    logic signed [DW-1:0]  w_new_dv;
    logic                  w_ram_we;
    logic                  w_out_free;
    logic signed [TW-1:0]  w_total;

    // settings check and span
    always_comb begin
        w_span = 8'($signed({1'b0, r_match})) - (8'($signed(r_gap)) <<< 1) + 8'sd1;
        w_ok   = (r_match != 4'd0) && r_mis[4] && ($signed(r_gap) < $signed(r_mis))
                 && (w_span <= 8'(MAX_SCORE_SPAN));
        w_scores.match_score    = r_match;
        w_scores.mismatch_score = r_mis;
        w_scores.gap_score      = r_gap;
        w_scores.span           = w_span;
        w_len = (8'(r_qlen) > 8'(QUERY_BITS)) ? CW'(QUERY_BITS) : CW'(r_qlen);
    end

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_out_free = !r_o_valid || i_m_axis_tready;

    always_comb begin
        w_eq = 1'b0;
        for (int k = 0; k < MS; k++) begin
            if (r_sym == 2'(k) && r_mask[k][r_paddr]) begin
                w_eq = 1'b1;
            end
        end
    end

    bpas_ram #(
        .WIDTH (IW),
        .DEPTH (QUERY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_paddr),
        .i_wdata (w_new_id),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    bpas_cell_unit #(
        .MAX_SCORE_SPAN (MAX_SCORE_SPAN)
    ) u_cell (
        .i_scores   (w_scores),
        .i_id       (w_rdata),
        .i_id_valid (r_rd_vld),
        .i_eq       (w_eq),
        .i_dv       (r_dv),
        .o_id       (w_new_id),
        .o_dh       (w_new_dh),
        .o_dv       (w_new_dv)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_s_axis_tuser) begin
                    if (w_ok) begin
                        n_state = S_RUN;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RUN: begin
                if (r_idx == w_len) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = r_last ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_ram_we        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            S_RUN: begin
                w_ram_we = r_pv;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_total = TW'(r_prod) + TW'(r_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_match      <= 4'd1;
            r_mis        <= 5'h1F;
            r_gap        <= 5'h1E;
            r_qlen       <= 7'd64;
            r_valid      <= '0;
            r_text_count <= '0;
            r_o_valid    <= 1'b0;
            for (int k = 0; k < MS; k++) begin
                r_mask[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    REG_MATCH:    r_match <= pwdata[3:0];
                    REG_MISMATCH: r_mis   <= pwdata[4:0];
                    REG_GAP:      r_gap   <= pwdata[4:0];
                    REG_QLEN:     r_qlen  <= pwdata[6:0];
                    default:      r_qlen  <= r_qlen;
                endcase
                r_valid      <= '0;
                r_text_count <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && !i_s_axis_tuser) begin
                        // position 0 clears every mask before its own bit goes in
                        for (int k = 0; k < MS; k++) begin
                            r_mask[k] <= ((i_s_axis_tdata[7:2] == 6'd0) ? '0 : r_mask[k])
                                | ((i_s_axis_tdata[1:0] == 2'(k)
                                    && 7'(i_s_axis_tdata[7:2]) < 7'(QUERY_BITS))
                                   ? (QUERY_BITS'(1) << i_s_axis_tdata[7:2]) : '0);
                        end
                        if (i_s_axis_tdata[7:2] == 6'd0) begin
                            r_valid      <= '0;
                            r_text_count <= '0;
                        end
                    end else if (w_in_acc && w_ok) begin
                        if (r_text_count != 32'hFFFF_FFFF) begin
                            r_text_count <= r_text_count + 32'd1;
                        end
                    end
                end
                S_RUN: begin
                    if (r_pv) begin
                        r_valid[r_paddr] <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_valid      <= '0;
                        r_text_count <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_paddr  <= r_idx[AW-1:0];
        r_rd_vld <= r_valid[r_idx[AW-1:0]];
        case (r_state)
            S_IDLE: begin
                r_sym       <= i_s_axis_tdata[1:0];
                r_last      <= i_s_axis_tlast;
                r_idx       <= '0;
                r_pv        <= 1'b0;
                r_dv        <= DW'($signed(r_gap));
                r_sum       <= '0;
                r_res_score <= '0;
                r_res_err   <= !w_ok;
            end
            S_RUN: begin
                if (r_pv) begin
                    r_dv  <= w_new_dv;
                    r_sum <= r_sum + SUMW'(w_new_dh);
                end
                if (r_idx != w_len) begin
                    r_idx <= r_idx + CW'(1);
                    r_pv  <= 1'b1;
                end else begin
                    r_pv  <= 1'b0;
                end
            end
            S_MUL: begin
                r_prod <= PW'($signed({1'b0, r_text_count})) * PW'($signed(r_gap));
            end
            S_SUM: begin
                if (w_total > TW'(32'sh7FFF_FFFF)) begin
                    r_res_score <= 32'h7FFF_FFFF;
                end else if (w_total < -TW'(33'sh0_8000_0000)) begin
                    r_res_score <= 32'h8000_0000;
                end else begin
                    r_res_score <= w_total[31:0];
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_o_score <= r_res_score;
                    r_o_err   <= r_res_err;
                end
            end
            default: begin
                r_pv <= 1'b0;
            end
        endcase
    end

    always_comb begin
        case (paddr[3:2])
            REG_MATCH:    prdata = {28'd0, r_match};
            REG_MISMATCH: prdata = {{27{r_mis[4]}}, r_mis};
            REG_GAP:      prdata = {{27{r_gap[4]}}, r_gap};
            REG_QLEN:     prdata = {25'd0, r_qlen};
            default:      prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_score;
    assign o_m_axis_tuser  = r_o_err;

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_idx <= w_len))
        else $error("position counter ran past the query length");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == 32'd0))
        else $error("error result carries a nonzero score");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> (r_text_count == 32'd0 && r_valid == '0))
        else $error("register write did not restart the text");

    a_ram_we_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == S_RUN && r_paddr == AW'(r_idx - CW'(1))))
        else $error("difference store written at the wrong position");
`endif

endmodule
